### rtl/core/lirs_pkg.sv
// Shared constants, rate tables and control types of the linear interpolation resampler.
package lirs_pkg;

   localparam int SAMPLE_WIDTH_DEFAULT = 32;
   localparam int IO_WIDTH             = 32;
   localparam int RATE_WIDTH           = 16;
   localparam int CSR_INDEX_WIDTH      = 2;
   localparam int FRAC_BITS            = 28;
   localparam int RATE_COUNT           = 9;
   localparam int RATE_IDX_WIDTH       = 4;
   localparam int TAB_IDX_WIDTH        = 7;
   localparam int MAX_OUT              = 7;
   localparam int COUNT_WIDTH          = 3;

   localparam logic [CSR_INDEX_WIDTH-1:0] REG_INPUT_RATE  = CSR_INDEX_WIDTH'(0);
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_OUTPUT_RATE = CSR_INDEX_WIDTH'(1);

   localparam logic [RATE_WIDTH-1:0] RATE_RESET = 16'd44100;

   localparam logic [31:0] PH_ONE    = 32'h1000_0000;
   localparam logic [31:0] SNAP_ADD  = 32'h0000_0080;
   localparam logic [31:0] SNAP_MASK = 32'h0fff_ff00;
   localparam logic [31:0] INT_MASK  = 32'hf000_0000;

   localparam logic [RATE_WIDTH-1:0] RATE_LIST [RATE_COUNT] = '{
      16'd48000, 16'd44100, 16'd32000, 16'd24000, 16'd22050,
      16'd16000, 16'd12000, 16'd11025, 16'd8000
   };

   // Row is the input rate, column the output rate, both in RATE_LIST order.
   localparam logic [31:0] RATIO_TABLE [RATE_COUNT*RATE_COUNT] = '{
      32'h10000000, 32'h116a3b36, 32'h18000000, 32'h20000000, 32'h22d4766c,
      32'h30000000, 32'h40000000, 32'h45a8ecd8, 32'h60000000,
      32'h0eb33333, 32'h10000000, 32'h160ccccd, 32'h1d666666, 32'h20000000,
      32'h2c19999a, 32'h3acccccd, 32'h40000000, 32'h58333333,
      32'h0aaaaaab, 32'h0b9c2779, 32'h10000000, 32'h15555555, 32'h17384ef3,
      32'h20000000, 32'h2aaaaaab, 32'h2e709de5, 32'h40000000,
      32'h08000000, 32'h08b51d9b, 32'h0c000000, 32'h10000000, 32'h116a3b36,
      32'h18000000, 32'h20000000, 32'h22d4766c, 32'h30000000,
      32'h0759999a, 32'h08000000, 32'h0b066666, 32'h0eb33333, 32'h10000000,
      32'h160ccccd, 32'h1d666666, 32'h20000000, 32'h2c19999a,
      32'h05555555, 32'h05ce13bd, 32'h08000000, 32'h0aaaaaab, 32'h0b9c2779,
      32'h10000000, 32'h15555555, 32'h17384ef3, 32'h20000000,
      32'h04000000, 32'h045a8ecd, 32'h06000000, 32'h08000000, 32'h08b51d9b,
      32'h0c000000, 32'h10000000, 32'h116a3b36, 32'h18000000,
      32'h03accccd, 32'h04000000, 32'h05833333, 32'h0759999a, 32'h08000000,
      32'h0b066666, 32'h0eb33333, 32'h10000000, 32'h160ccccd,
      32'h02aaaaab, 32'h02e709de, 32'h04000000, 32'h05555555, 32'h05ce13bd,
      32'h08000000, 32'h0aaaaaab, 32'h0b9c2779, 32'h10000000
   };

   // Datapath operations selected by one control word.
   typedef struct packed {
      logic listen;
      logic take;
      logic load_diff;
      logic mul;
      logic emit;
      logic finish;
      logic pass_emit;
      logic commit;
   } ctrl_type;

   // Conditions the sequencer may wait on or branch on.
   typedef struct packed {
      logic no_req;
      logic pass;
      logic no_prev;
      logic loop_done;
      logic out_busy;
   } status_type;

   typedef struct packed {
      logic                      hit;
      logic [RATE_IDX_WIDTH-1:0] idx;
   } rate_hit_type;

   function automatic rate_hit_type rate_lookup(input logic [RATE_WIDTH-1:0] rate);
      rate_hit_type res;
      res = '0;
      for (int i = RATE_COUNT - 1; i >= 0; i--) begin
         if (RATE_LIST[i] == rate) begin
            res.hit = 1'b1;
            res.idx = RATE_IDX_WIDTH'(i);
         end
      end
      return res;
   endfunction

endpackage

### rtl/core/lirs_seq.sv
// Microcoded sequencer: step counter, control program table and branch logic.
module lirs_seq (
   input  logic                clock,
   input  logic                reset,
   input  lirs_pkg::status_type status,
   output lirs_pkg::ctrl_type   ctrl
);
   import lirs_pkg::*;

   typedef enum logic [2:0] {
      C_NEVER,
      C_ALWAYS,
      C_NO_REQ,
      C_PASS,
      C_NO_PREV,
      C_LOOP_DONE,
      C_OUT_BUSY
   } cond_type;

   typedef struct packed {
      cond_type   hold;
      cond_type   jump;
      logic [2:0] target;
      ctrl_type   ops;
   } word_type;

   localparam logic [2:0] STEP_WAIT   = 3'd0;
   localparam logic [2:0] STEP_CHECK  = 3'd1;
   localparam logic [2:0] STEP_PREV   = 3'd2;
   localparam logic [2:0] STEP_LOOP   = 3'd3;
   localparam logic [2:0] STEP_EMIT   = 3'd4;
   localparam logic [2:0] STEP_FINISH = 3'd5;
   localparam logic [2:0] STEP_PASS   = 3'd6;
   localparam logic [2:0] STEP_STORE  = 3'd7;

   // A step waits while its hold condition is true; otherwise its operations
   // fire and it branches to its target if the jump condition is true.
   function automatic word_type program_word(input logic [2:0] s);
      word_type w;
      w = '{hold: C_NEVER, jump: C_NEVER, target: STEP_WAIT, ops: '0};
      case (s)
         STEP_WAIT: begin
            w.hold       = C_NO_REQ;
            w.ops.listen = 1'b1;
            w.ops.take   = 1'b1;
         end
         STEP_CHECK: begin
            w.jump   = C_PASS;
            w.target = STEP_PASS;
         end
         STEP_PREV: begin
            w.jump          = C_NO_PREV;
            w.target        = STEP_STORE;
            w.ops.load_diff = 1'b1;
         end
         STEP_LOOP: begin
            w.jump    = C_LOOP_DONE;
            w.target  = STEP_FINISH;
            w.ops.mul = 1'b1;
         end
         STEP_EMIT: begin
            w.hold     = C_OUT_BUSY;
            w.jump     = C_ALWAYS;
            w.target   = STEP_LOOP;
            w.ops.emit = 1'b1;
         end
         STEP_FINISH: begin
            w.jump       = C_ALWAYS;
            w.target     = STEP_WAIT;
            w.ops.finish = 1'b1;
            w.ops.commit = 1'b1;
         end
         STEP_PASS: begin
            w.hold          = C_OUT_BUSY;
            w.jump          = C_ALWAYS;
            w.target        = STEP_WAIT;
            w.ops.pass_emit = 1'b1;
            w.ops.commit    = 1'b1;
         end
         STEP_STORE: begin
            w.jump       = C_ALWAYS;
            w.target     = STEP_WAIT;
            w.ops.commit = 1'b1;
         end
         default: w = '{hold: C_NEVER, jump: C_ALWAYS, target: STEP_WAIT, ops: '0};
      endcase
      return w;
   endfunction

   function automatic logic cond_true(input cond_type c, input status_type st);
      logic res;
      case (c)
         C_NEVER:     res = 1'b0;
         C_ALWAYS:    res = 1'b1;
         C_NO_REQ:    res = st.no_req;
         C_PASS:      res = st.pass;
         C_NO_PREV:   res = st.no_prev;
         C_LOOP_DONE: res = st.loop_done;
         C_OUT_BUSY:  res = st.out_busy;
         default:     res = 1'b0;
      endcase
      return res;
   endfunction

   logic [2:0] step_ff;
   logic [2:0] step_in;
   word_type   word;
   logic       held;

   always_comb begin
      word = program_word(step_ff);
      held = cond_true(word.hold, status);
      ctrl = word.ops;
      if (held) begin
         ctrl        = '0;
         ctrl.listen = word.ops.listen;
         step_in     = step_ff;
      end else if (cond_true(word.jump, status)) begin
         step_in = word.target;
      end else begin
         step_in = step_ff + 3'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= STEP_WAIT;
      end else begin
         step_ff <= step_in;
      end
   end

endmodule

### rtl/core/linear_interp_resampler_top.sv
// Top level of the linear interpolation resampler: ports, rate registers and datapath.
// Linear interpolation sample rate converter. Each input item is a signed 4.28
// sample; results are prev + (cur - prev) * phase taken while the phase is below
// one, the phase stepping by the ratio of the configured input and output rates
// (nine standard rates from 8000 to 48000 Hz). Equal rates and unsupported rates
// pass the sample straight through, the latter with rate_unsupported set. One
// item is handled at a time by a small control program driving one shared
// multiplier. Each of up to seven interpolated results takes one multiply step
// and one output step; a passthrough item skips the multiplier and the very first
// sample is only stored. A busy output side holds the output steps. The user must
// write the rate registers through the csr_ port only while the block is idle;
// the block does not enforce this. A new rate takes effect on the next item.
module linear_interp_resampler_top #(
   parameter int SAMPLE_WIDTH = lirs_pkg::SAMPLE_WIDTH_DEFAULT
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [lirs_pkg::CSR_INDEX_WIDTH-1:0]  csr_index,
   input  logic [lirs_pkg::RATE_WIDTH-1:0]       csr_wdata,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic signed [lirs_pkg::IO_WIDTH-1:0]  req_sample,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic signed [lirs_pkg::IO_WIDTH-1:0]  rsp_out_sample,
   output logic                                  rsp_last_in_run,
   output logic                                  rsp_rate_unsupported
);
   import lirs_pkg::*;

   localparam int DIFF_W = SAMPLE_WIDTH + 1;
   localparam int PROD_W = SAMPLE_WIDTH + FRAC_BITS + 2;

   ctrl_type   ctrl;
   status_type status;

   logic [RATE_WIDTH-1:0] in_rate_ff, in_rate_in;
   logic [RATE_WIDTH-1:0] out_rate_ff, out_rate_in;

   logic signed [SAMPLE_WIDTH-1:0] cur_ff, cur_in;
   logic signed [SAMPLE_WIDTH-1:0] prev_ff, prev_in;
   logic                           have_prev_ff, have_prev_in;
   logic [31:0]                    phase_ff, phase_in;
   logic [31:0]                    ratio_ff, ratio_in;
   logic                           pass_ff, pass_in;
   logic                           unsup_ff, unsup_in;
   logic signed [DIFF_W-1:0]       diff_ff, diff_in;
   logic signed [PROD_W-1:0]       prod_ff, prod_in;
   logic [COUNT_WIDTH-1:0]         count_ff, count_in;

   logic                           rsp_valid_ff, rsp_valid_in;
   logic signed [IO_WIDTH-1:0]     rsp_sample_ff, rsp_sample_in;
   logic                           rsp_last_ff, rsp_last_in;
   logic                           rsp_unsup_ff, rsp_unsup_in;

   rate_hit_type                   in_hit, out_hit;
   logic [TAB_IDX_WIDTH-1:0]       tab_idx;
   logic [31:0]                    ratio_lookup;
   logic [31:0]                    phase_sum;
   logic [31:0]                    phase_rnd;
   logic [31:0]                    phase_step;
   logic signed [SAMPLE_WIDTH-1:0] interp;
   logic                           out_free;

   lirs_seq u_seq (
      .clock  (clock),
      .reset  (reset),
      .status (status),
      .ctrl   (ctrl)
   );

   assign csr_ready = 1'b1;
   assign req_ready = ctrl.listen;

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_out_sample       = rsp_sample_ff;
   assign rsp_last_in_run      = rsp_last_ff;
   assign rsp_rate_unsupported = rsp_unsup_ff;

   assign out_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      in_hit       = rate_lookup(in_rate_ff);
      out_hit      = rate_lookup(out_rate_ff);
      tab_idx      = TAB_IDX_WIDTH'(in_hit.idx) * TAB_IDX_WIDTH'(RATE_COUNT)
                     + TAB_IDX_WIDTH'(out_hit.idx);
      ratio_lookup = RATIO_TABLE[tab_idx];

      // Phase after one output step, with near-integer values snapped.
      phase_sum = phase_ff + ratio_ff;
      phase_rnd = phase_sum + SNAP_ADD;
      if ((phase_rnd & SNAP_MASK) == 32'd0) begin
         phase_step = phase_rnd & INT_MASK;
      end else begin
         phase_step = phase_sum;
      end

      // The product is exact; the arithmetic shift floors it.
      interp = prev_ff + prod_ff[FRAC_BITS +: SAMPLE_WIDTH];

      status.no_req    = !req_valid;
      status.pass      = pass_ff;
      status.no_prev   = !have_prev_ff;
      status.loop_done = (phase_ff[31:FRAC_BITS] != '0)
                         || (count_ff == COUNT_WIDTH'(MAX_OUT));
      status.out_busy  = !out_free;
   end

   always_comb begin
      in_rate_in    = in_rate_ff;
      out_rate_in   = out_rate_ff;
      cur_in        = cur_ff;
      prev_in       = prev_ff;
      have_prev_in  = have_prev_ff;
      phase_in      = phase_ff;
      ratio_in      = ratio_ff;
      pass_in       = pass_ff;
      unsup_in      = unsup_ff;
      diff_in       = diff_ff;
      prod_in       = prod_ff;
      count_in      = count_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_sample_in = rsp_sample_ff;
      rsp_last_in   = rsp_last_ff;
      rsp_unsup_in  = rsp_unsup_ff;

      if (csr_valid) begin
         case (csr_index)
            REG_INPUT_RATE:  in_rate_in  = csr_wdata;
            REG_OUTPUT_RATE: out_rate_in = csr_wdata;
            default: ;
         endcase
      end

      if (ctrl.take) begin
         cur_in   = req_sample[SAMPLE_WIDTH-1:0];
         ratio_in = ratio_lookup;
         unsup_in = !in_hit.hit || !out_hit.hit;
         pass_in  = !in_hit.hit || !out_hit.hit || (ratio_lookup == PH_ONE);
         count_in = '0;
      end

      if (ctrl.load_diff) begin
         diff_in = DIFF_W'(cur_ff) - DIFF_W'(prev_ff);
      end

      if (ctrl.mul) begin
         prod_in = PROD_W'(diff_ff) * PROD_W'($signed({1'b0, phase_ff[FRAC_BITS-1:0]}));
      end

      if (ctrl.emit) begin
         rsp_valid_in  = 1'b1;
         rsp_sample_in = IO_WIDTH'(interp);
         rsp_unsup_in  = 1'b0;
         rsp_last_in   = (phase_step[31:FRAC_BITS] != '0)
                         || (count_ff == COUNT_WIDTH'(MAX_OUT - 1));
         phase_in      = phase_step;
         count_in      = count_ff + COUNT_WIDTH'(1);
      end

      if (ctrl.pass_emit) begin
         rsp_valid_in  = 1'b1;
         rsp_sample_in = IO_WIDTH'(cur_ff);
         rsp_unsup_in  = unsup_ff;
         rsp_last_in   = 1'b1;
      end

      if (ctrl.finish && (phase_ff[31:FRAC_BITS] != '0)) begin
         phase_in = phase_ff - PH_ONE;
      end

      if (ctrl.commit) begin
         prev_in      = cur_ff;
         have_prev_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_rate_ff   <= RATE_RESET;
         out_rate_ff  <= RATE_RESET;
         prev_ff      <= '0;
         have_prev_ff <= 1'b0;
         phase_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_rate_ff   <= in_rate_in;
         out_rate_ff  <= out_rate_in;
         prev_ff      <= prev_in;
         have_prev_ff <= have_prev_in;
         phase_ff     <= phase_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff        <= cur_in;
      ratio_ff      <= ratio_in;
      pass_ff       <= pass_in;
      unsup_ff      <= unsup_in;
      diff_ff       <= diff_in;
      prod_ff       <= prod_in;
      count_ff      <= count_in;
      rsp_sample_ff <= rsp_sample_in;
      rsp_last_ff   <= rsp_last_in;
      rsp_unsup_ff  <= rsp_unsup_in;
   end

endmodule
